// ===== sv/mfr_pkg.sv =====
package mfr_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = ($clog2(BUF_DEPTH + 1) > 9) ? $clog2(BUF_DEPTH + 1) : 9;
    localparam int HDR_N     = 4;
    localparam int HDR_W     = $clog2(HDR_N);

    localparam logic [7:0] LEAD_DEV = 8'hC1;
    localparam logic [7:0] LEAD_LEN = 8'h55;
    localparam logic [7:0] LEAD_OK  = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] DEV_B1   = 8'hC2;
    localparam logic [7:0] DEV_B2   = 8'hC3;
    localparam logic [7:0] DEV_B3   = 8'hC4;

    localparam logic OP_RX      = 1'b0;
    localparam logic OP_READ    = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [1:0] {
        FT_LEN  = 2'd0,
        FT_DEV  = 2'd1,
        FT_OK   = 2'd2,
        FT_LINE = 2'd3
    } frame_type_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } init_state_t;

    typedef struct packed {
        logic        kind;
        frame_type_t frame_type;
        logic [8:0]  frame_length;
        logic [7:0]  data;
        logic        use_ram;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== sv/mfr_ram.sv =====
module mfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mfr_ctrl.sv =====
module mfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              operation,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        read_index,
    output logic              run,
    output logic              res_valid,
    output mfr_pkg::res_t     res,
    output mfr_pkg::mem_req_t mem_req
);

    mfr_pkg::init_state_t              state_reg, state_next;
    logic [mfr_pkg::ADDR_W-1:0]        clr_reg, clr_next;
    logic [7:0]                        hdr_reg [mfr_pkg::HDR_N];
    logic [7:0]                        hdr_next [mfr_pkg::HDR_N];
    logic [7:0]                        hdr_put [mfr_pkg::HDR_N];
    logic [mfr_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                              cr_reg, cr_next;

    logic [mfr_pkg::CNT_W-1:0]         cnt_inc;
    logic [mfr_pkg::CNT_W-1:0]         want;
    logic [mfr_pkg::CNT_W-1:0]         idx_ext;
    logic [7:0]                        lead;
    logic                              rx, rd, put, restart, done;
    logic                              in_range, is_hdr;

    assign run     = (state_reg == mfr_pkg::ST_RUN);
    assign rx      = accept && run && (operation == mfr_pkg::OP_RX);
    assign rd      = accept && run && (operation == mfr_pkg::OP_READ);
    assign lead    = hdr_reg[0];
    assign cnt_inc = cnt_reg + mfr_pkg::CNT_W'(1);
    assign idx_ext = mfr_pkg::CNT_W'(read_index);
    assign in_range = idx_ext < mfr_pkg::CNT_W'(mfr_pkg::BUF_DEPTH);
    assign is_hdr   = idx_ext < mfr_pkg::CNT_W'(mfr_pkg::HDR_N);

    // header bytes as they stand once the incoming byte is stored at the count
    always_comb
    begin
        for (int i = 0; i < mfr_pkg::HDR_N; i++)
        begin
            hdr_put[i] = hdr_reg[i];
        end
        if (cnt_reg < mfr_pkg::CNT_W'(mfr_pkg::HDR_N))
        begin
            hdr_put[cnt_reg[mfr_pkg::HDR_W-1:0]] = rx_byte;
        end
    end

    assign want = mfr_pkg::CNT_W'(hdr_put[1]) + mfr_pkg::CNT_W'(2);

    always_comb
    begin
        for (int i = 0; i < mfr_pkg::HDR_N; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        cnt_next = cnt_reg;
        cr_next  = cr_reg;
        put      = 1'b0;
        restart  = 1'b0;
        done     = 1'b0;
        res      = '0;

        if (rx)
        begin
            priority if (lead == mfr_pkg::LEAD_DEV)
            begin
                if (cr_reg)
                begin
                    if (rx_byte != mfr_pkg::CH_LF)
                    begin
                        cnt_next = '0;
                        cr_next  = 1'b0;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                else if (rx_byte == mfr_pkg::CH_CR)
                begin
                    cr_next = 1'b1;
                end
                else
                begin
                    put      = 1'b1;
                    cnt_next = (cnt_inc >= mfr_pkg::CNT_W'(mfr_pkg::BUF_DEPTH)) ? '0 : cnt_inc;
                end
            end
            else if (lead == mfr_pkg::LEAD_LEN)
            begin
                put      = 1'b1;
                cnt_next = cnt_inc;
                if (want == cnt_inc)
                begin
                    done = 1'b1;
                end
                else if (want < cnt_inc)
                begin
                    restart = 1'b1;
                end
            end
            else if (lead == mfr_pkg::LEAD_OK)
            begin
                put      = 1'b1;
                cnt_next = cnt_inc;
                if (hdr_put[1] == mfr_pkg::CH_K)
                begin
                    done = 1'b1;
                end
                else if (cnt_inc >= mfr_pkg::CNT_W'(2))
                begin
                    restart = 1'b1;
                end
            end
            else if (lead == 8'h00)
            begin
                if (rx_byte != 8'h00)
                begin
                    hdr_next[1] = 8'h00;
                    hdr_next[0] = rx_byte;
                    cnt_next    = mfr_pkg::CNT_W'(1);
                end
            end
            else
            begin
                for (int i = 1; i < mfr_pkg::HDR_N; i++)
                begin
                    hdr_next[i] = 8'h00;
                end
                hdr_next[0] = rx_byte;
                cnt_next    = mfr_pkg::CNT_W'(1);
                cr_next     = 1'b0;
            end

            if (put)
            begin
                for (int i = 0; i < mfr_pkg::HDR_N; i++)
                begin
                    hdr_next[i] = hdr_put[i];
                end
            end
            if (restart)
            begin
                cnt_next    = '0;
                cr_next     = 1'b0;
                hdr_next[0] = 8'h00;
                hdr_next[1] = 8'h00;
            end
            if (done)
            begin
                res.kind         = mfr_pkg::KIND_FRAME;
                res.frame_length = cnt_next[8:0];
                priority if (hdr_next[0] == mfr_pkg::LEAD_LEN)
                begin
                    res.frame_type = mfr_pkg::FT_LEN;
                end
                else if (hdr_next[0] == mfr_pkg::LEAD_DEV && hdr_next[1] == mfr_pkg::DEV_B1
                         && hdr_next[2] == mfr_pkg::DEV_B2 && hdr_next[3] == mfr_pkg::DEV_B3)
                begin
                    res.frame_type = mfr_pkg::FT_DEV;
                end
                else if (hdr_next[0] == mfr_pkg::LEAD_OK)
                begin
                    res.frame_type = mfr_pkg::FT_OK;
                end
                else
                begin
                    res.frame_type = mfr_pkg::FT_LINE;
                end
                cnt_next    = '0;
                cr_next     = 1'b0;
                hdr_next[0] = 8'h00;
            end
        end
        else if (rd)
        begin
            res.kind    = mfr_pkg::KIND_READ;
            res.use_ram = in_range && !is_hdr;
            res.data    = (in_range && is_hdr) ? hdr_reg[read_index[mfr_pkg::HDR_W-1:0]] : 8'h00;
        end
    end

    assign res_valid = rd || done;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        mem_req    = '0;
        unique case (state_reg)
            mfr_pkg::ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                clr_next      = clr_reg + mfr_pkg::ADDR_W'(1);
                if (clr_reg == mfr_pkg::ADDR_W'(mfr_pkg::BUF_DEPTH - 1))
                begin
                    state_next = mfr_pkg::ST_RUN;
                end
            end
            mfr_pkg::ST_RUN:
            begin
                mem_req.we    = put && (cnt_reg >= mfr_pkg::CNT_W'(mfr_pkg::HDR_N))
                                && (cnt_reg < mfr_pkg::CNT_W'(mfr_pkg::BUF_DEPTH));
                mem_req.waddr = cnt_reg[mfr_pkg::ADDR_W-1:0];
                mem_req.wdata = rx_byte;
                mem_req.re    = rd && in_range && !is_hdr;
                mem_req.raddr = idx_ext[mfr_pkg::ADDR_W-1:0];
            end
            default:
            begin
                state_next = mfr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfr_pkg::ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            cr_reg    <= 1'b0;
            for (int i = 0; i < mfr_pkg::HDR_N; i++)
            begin
                hdr_reg[i] <= 8'h00;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            cr_reg    <= cr_next;
            for (int i = 0; i < mfr_pkg::HDR_N; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

endmodule

// ===== sv/mfr_out.sv =====
module mfr_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    input  mfr_pkg::res_t res,
    input  logic [7:0]    ram_rdata,
    output logic          can_take,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,   // frame_type[1:0], frame_length[10:2], read_data[18:11]
    output logic          m_tuser    // result_kind
);

    logic          s1_valid_reg;
    mfr_pkg::res_t s1_reg;
    logic          out_valid_reg;
    logic          out_kind_reg;
    logic [1:0]    out_type_reg;
    logic [8:0]    out_len_reg;
    logic [7:0]    out_data_reg;
    logic          s1_adv;

    assign s1_adv   = !out_valid_reg || m_tready;
    assign can_take = !s1_valid_reg || s1_adv;

    // RAM read data stays put until the next read, which needs s1 to move
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_take)
            begin
                s1_valid_reg <= res_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && res_valid)
        begin
            s1_reg <= res;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_kind_reg <= s1_reg.kind;
            out_type_reg <= s1_reg.frame_type;
            out_len_reg  <= s1_reg.frame_length;
            out_data_reg <= s1_reg.use_ram ? ram_rdata : s1_reg.data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b0, out_data_reg, out_len_reg, out_type_reg};

endmodule

// ===== sv/multi_format_frame_receiver_core.sv =====
// channel | dir | tdata                              | tuser
// s_      | in  | rx_byte[7:0], read_index[15:8]      | operation
// m_      | out | frame_type[1:0], frame_length[10:2], | result_kind
//         |     | read_data[18:11]                    |
//
// One item per cycle in steady state while m_ is ready; a result reaches m_ through
// the result register (beside the store's registered read) and then the output
// register.
// After reset a clearing pass writes zero to all BUF_DEPTH store entries, one a
// cycle; s_tready stays low until it ends.
// A stalled m_ side backs up through a two-entry result pipe into s_tready.
module multi_format_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], read_index[15:8]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // frame_type[1:0], frame_length[10:2], read_data[18:11]
    output logic        m_tuser    // result_kind
);

    logic              run;
    logic              can_take;
    logic              accept;
    logic              res_valid;
    mfr_pkg::res_t     res;
    mfr_pkg::mem_req_t mem_req;
    logic [7:0]        ram_rdata;

    assign s_tready = run && can_take;
    assign accept   = s_tvalid && s_tready;

    mfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (s_tuser),
        .rx_byte    (s_tdata[7:0]),
        .read_index (s_tdata[15:8]),
        .run        (run),
        .res_valid  (res_valid),
        .res        (res),
        .mem_req    (mem_req)
    );

    mfr_ram #(
        .WIDTH (8),
        .DEPTH (mfr_pkg::BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    mfr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .ram_rdata (ram_rdata),
        .can_take  (can_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == mfr_pkg::OP_READ) |-> res_valid)
        else $error("read item produced no result");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == mfr_pkg::OP_READ) |-> !mem_req.we)
        else $error("store written by a read item");

    a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
        !run |-> (mem_req.we && !mem_req.re && !s_tready))
        else $error("clearing pass not exclusive");

    a_read_port_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.re |-> (accept && res_valid && res.use_ram))
        else $error("store read without a read item");

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                 kind;
        mfr_pkg::frame_type_t ftype;
        logic [8:0]           flen;
        logic [7:0]           rdata;
    } rx_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // rx_byte[7:0], read_index[15:8]
    logic        s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;   // frame_type[1:0], frame_length[10:2], read_data[18:11]
    logic        m_tuser;   // result_kind

    logic [7:0]  line_store [mfr_pkg::BUF_DEPTH];
    int unsigned stored_bytes;
    bit          cr_pending;
    rx_result_t  awaited_results [$];
    int          mismatches;
    int          items_sent;
    int          idle_pct;
    int          ready_hold;
    bit          mix_reads;

    multi_format_frame_receiver_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic void store_byte(input int unsigned pos, input logic [7:0] value);
        if (pos < mfr_pkg::BUF_DEPTH)
            line_store[pos] = value;
    endfunction

    function automatic void restart_frame();
        stored_bytes  = 0;
        cr_pending    = 1'b0;
        line_store[0] = 8'h00;
        line_store[1] = 8'h00;
    endfunction

    function automatic void advance_receiver(input logic op, input logic [7:0] rx_b,
                                             input logic [7:0] idx);
        rx_result_t  res;
        logic [7:0]  lead;
        bit          done;
        int unsigned want_count;
        done      = 1'b0;
        res.kind  = mfr_pkg::KIND_FRAME;
        res.ftype = mfr_pkg::FT_LEN;
        res.flen  = '0;
        res.rdata = '0;
        if (op == mfr_pkg::OP_READ)
        begin
            res.kind  = mfr_pkg::KIND_READ;
            res.rdata = (int'(idx) < mfr_pkg::BUF_DEPTH) ? line_store[idx] : 8'h00;
            awaited_results.push_back(res);
            return;
        end
        lead = line_store[0];
        if (lead == mfr_pkg::LEAD_DEV)
        begin
            if (cr_pending)
            begin
                if (rx_b != mfr_pkg::CH_LF)
                begin
                    stored_bytes = 0;
                    cr_pending   = 1'b0;
                end
                else
                    done = 1'b1;
            end
            else if (rx_b == mfr_pkg::CH_CR)
                cr_pending = 1'b1;
            else
            begin
                store_byte(stored_bytes, rx_b);
                stored_bytes++;
                if (stored_bytes > mfr_pkg::BUF_DEPTH - 1)
                    stored_bytes = 0;
            end
        end
        else if (lead == mfr_pkg::LEAD_LEN)
        begin
            store_byte(stored_bytes, rx_b);
            stored_bytes++;
            want_count = line_store[1] + 2;
            if (want_count == stored_bytes)
                done = 1'b1;
            else if (want_count < stored_bytes)
                restart_frame();
        end
        else if (lead == mfr_pkg::LEAD_OK)
        begin
            store_byte(stored_bytes, rx_b);
            stored_bytes++;
            if (line_store[1] == mfr_pkg::CH_K)
                done = 1'b1;
            else if (stored_bytes >= 2)
                restart_frame();
        end
        else if (lead == 8'h00)
        begin
            if (rx_b != 8'h00)
            begin
                line_store[1] = 8'h00;
                line_store[0] = rx_b;
                stored_bytes  = 1;
            end
        end
        else
        begin
            line_store[1] = 8'h00;
            line_store[2] = 8'h00;
            line_store[3] = 8'h00;
            line_store[0] = rx_b;
            stored_bytes  = 1;
            cr_pending    = 1'b0;
        end
        if (done)
        begin
            if (line_store[0] == mfr_pkg::LEAD_LEN)
                res.ftype = mfr_pkg::FT_LEN;
            else if (line_store[0] == mfr_pkg::LEAD_DEV &&
                     line_store[1] == mfr_pkg::DEV_B1 &&
                     line_store[2] == mfr_pkg::DEV_B2 &&
                     line_store[3] == mfr_pkg::DEV_B3)
                res.ftype = mfr_pkg::FT_DEV;
            else if (line_store[0] == mfr_pkg::LEAD_OK)
                res.ftype = mfr_pkg::FT_OK;
            else
                res.ftype = mfr_pkg::FT_LINE;
            res.flen = stored_bytes[8:0];
            awaited_results.push_back(res);
            stored_bytes  = 0;
            cr_pending    = 1'b0;
            line_store[0] = 8'h00;
        end
    endfunction

    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == mfr_pkg::CH_CR);
        return b;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] rx_b, input logic [7:0] idx);
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {idx, rx_b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_receiver(op, rx_b, idx);
        items_sent++;
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_item(mfr_pkg::OP_READ, 8'($urandom), idx);
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (mix_reads && $urandom_range(0, 9) == 0)
            send_read(8'($urandom));
        send_item(mfr_pkg::OP_RX, b, 8'($urandom));
    endtask

    // finish whatever frame is open so the next byte is taken as a lead
    task automatic drive_to_idle();
        while (line_store[0] != 8'h00)
        begin
            case (line_store[0])
                mfr_pkg::LEAD_DEV: send_byte(cr_pending ? mfr_pkg::CH_LF : mfr_pkg::CH_CR);
                mfr_pkg::LEAD_LEN: send_byte(8'($urandom));
                mfr_pkg::LEAD_OK:  send_byte(mfr_pkg::CH_K);
                default:           send_byte(8'h00);
            endcase
        end
    endtask

    task automatic test_reads_after_clear();
        send_read(8'h00);
        send_read(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_length_frames();
        send_byte(mfr_pkg::LEAD_LEN);
        send_byte(8'h00);
        send_byte(mfr_pkg::LEAD_LEN);
        send_byte(8'h01);
        send_byte(8'hFF);
    endtask

    task automatic test_ok_replies();
        send_byte(mfr_pkg::LEAD_OK);
        send_byte(mfr_pkg::CH_K);
        send_byte(mfr_pkg::LEAD_OK);
        send_byte(8'h00);
    endtask

    task automatic test_device_lines();
        send_byte(mfr_pkg::LEAD_DEV);
        send_byte(mfr_pkg::DEV_B1);
        send_byte(mfr_pkg::DEV_B2);
        send_byte(mfr_pkg::DEV_B3);
        send_byte(mfr_pkg::CH_CR);
        send_byte(mfr_pkg::CH_LF);
        // CR then a non-LF byte restarts the count, lead kept
        send_byte(mfr_pkg::LEAD_DEV);
        send_byte(mfr_pkg::CH_CR);
        send_byte(8'h41);
        send_byte(mfr_pkg::CH_CR);
        send_byte(mfr_pkg::CH_LF);
    endtask

    task automatic test_lead_replacement();
        send_byte(8'h7E);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_read(8'h01);
        send_read(8'h02);
    endtask

    // 255 stored bytes wrap the count; the byte after the wrap lands on the lead slot
    task automatic test_line_overflow();
        drive_to_idle();
        send_byte(mfr_pkg::LEAD_DEV);
        repeat (255) send_byte(line_byte());
        send_byte(mfr_pkg::LEAD_DEV);
        repeat (10) send_byte(line_byte());
        send_byte(mfr_pkg::CH_CR);
        send_byte(mfr_pkg::CH_LF);
        send_read(8'h00);
        send_read(8'hFE);
    endtask

    task automatic test_random_traffic(input int n, input bit vary_idle);
        int         last;
        int         sel;
        int         len;
        logic [7:0] b;
        last      = items_sent + n;
        mix_reads = 1'b1;
        while (items_sent < last)
        begin
            if (vary_idle && $urandom_range(0, 7) == 0)
                idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            sel = $urandom_range(0, 99);
            if (sel < 72)
            begin
                drive_to_idle();
                if (sel < 24)
                begin
                    len = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 255)
                                                       : $urandom_range(0, 12);
                    send_byte(mfr_pkg::LEAD_LEN);
                    send_byte(8'(len));
                    repeat (len) send_byte(8'($urandom));
                end
                else if (sel < 52)
                begin
                    send_byte(mfr_pkg::LEAD_DEV);
                    if ($urandom_range(0, 1))
                    begin
                        send_byte(mfr_pkg::DEV_B1);
                        send_byte(mfr_pkg::DEV_B2);
                        send_byte(mfr_pkg::DEV_B3);
                    end
                    repeat ($urandom_range(0, 10)) send_byte(line_byte());
                    send_byte(mfr_pkg::CH_CR);
                    if ($urandom_range(0, 9) != 0)
                        send_byte(mfr_pkg::CH_LF);
                    else
                    begin
                        do
                            b = 8'($urandom);
                        while (b == mfr_pkg::CH_LF);
                        send_byte(b);
                    end
                end
                else
                begin
                    send_byte(mfr_pkg::LEAD_OK);
                    send_byte(($urandom_range(0, 4) != 0) ? mfr_pkg::CH_K : 8'($urandom));
                end
            end
            else if (sel < 84)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
            end
            else if (sel < 93)
                send_read(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                                      : 8'($urandom));
            else
            begin
                send_byte(8'($urandom));
                send_byte(8'($urandom));
            end
        end
        mix_reads = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else if (idle_pct > 0 && $urandom_range(1, 400) <= idle_pct)
        begin
            ready_hold = $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d tdata %h", m_tuser, m_tdata);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[1:0] !== want.ftype ||
                    m_tdata[10:2] !== want.flen || m_tdata[18:11] !== want.rdata ||
                    m_tdata[23:19] !== 5'b0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind %0d type %0d len %0d data %h, ",
                                  "got kind %0d type %0d len %0d data %h (tdata %h)"},
                                 want.kind, want.ftype, want.flen, want.rdata,
                                 m_tuser, m_tdata[1:0], m_tdata[10:2], m_tdata[18:11],
                                 m_tdata);
                end
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= mfr_pkg::OP_RX;
        for (int i = 0; i < mfr_pkg::BUF_DEPTH; i++)
            line_store[i] = 8'h00;
        stored_bytes = 0;
        cr_pending   = 1'b0;
        mismatches   = 0;
        items_sent   = 0;
        ready_hold   = 0;
        mix_reads    = 1'b0;
        idle_pct     = 20;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reads_after_clear();
        test_length_frames();
        test_ok_replies();
        test_device_lines();
        test_lead_replacement();
        test_random_traffic(450, 1'b1);
        test_line_overflow();
        test_random_traffic(200, 1'b1);
        idle_pct = 0;
        test_random_traffic(150, 1'b0);
        drive_to_idle();

        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("multi_format_frame_receiver_core test passed");
        else
            $display("multi_format_frame_receiver_core test failed");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("multi_format_frame_receiver_core test failed");
        $finish;
    end

endmodule
